// File: sv/dfa_pkg.sv
// Shared constants, types and codes for the decimal float to ASCII formatter.
package dfa_pkg;

    // Field widths and limits of the formatter.
    localparam int MANT_DIGITS = 16;
    localparam int CHUNK_CHARS = 8;
    localparam int MAX_RESULTS = 13;
    localparam int MANT_W      = 54;
    localparam int EXP_W       = 8;
    localparam int EXP_LOW     = -96;
    localparam int EXP_HIGH    = 80;
    localparam int BCD_W       = 4 * MANT_DIGITS;
    localparam int CHARS_W     = 8 * CHUNK_CHARS;
    localparam int CNT_W       = 4;
    localparam int TEXT_MAX    = MAX_RESULTS * CHUNK_CHARS;
    localparam int POS_W       = $clog2(TEXT_MAX + 1);
    localparam int STEP_W      = $clog2(MANT_W + 1);
    localparam int ND_W        = $clog2(MANT_DIGITS + 1);
    localparam int CIDX_W      = (CHUNK_CHARS > 1) ? $clog2(CHUNK_CHARS) : 1;
    localparam int WIDE_W      = 10;

    // Largest mantissa of MANT_DIGITS decimal digits.
    localparam logic [MANT_W-1:0] MANT_CEIL = MANT_W'(64'd9999999999999999);

    // ASCII codes used in the text.
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_STRIP,
        ST_NORM,
        ST_SETUP,
        ST_EMIT
    } t_state;

    // Operations of the shared BCD shift unit.
    typedef enum logic [2:0] {
        BOP_HOLD,
        BOP_LOAD,
        BOP_DABBLE,
        BOP_SHR,
        BOP_SHL
    } t_bcd_op;

    // Layout of the text.
    typedef enum logic [1:0] {
        FM_ZERO,
        FM_INT,
        FM_POINT,
        FM_FRAC
    } t_mode;

    // Status of the BCD register seen by the sequencer.
    typedef struct packed {
        logic       low_zero;
        logic       top_zero;
        logic [3:0] top_digit;
    } t_bcd_stat;

    // Text layout worked out once per item.
    typedef struct packed {
        t_mode            mode;
        logic             neg;
        logic [POS_W-1:0] split;
        logic [POS_W-1:0] len;
    } t_fmt;

    // One chunk of text ready for the output register.
    typedef struct packed {
        logic [CHARS_W-1:0] chars;
        logic [CNT_W-1:0]   count;
        logic               last;
    } t_chunk;

endpackage

// File: sv/dfa_bcd_unit.sv
// Shared BCD shift unit: binary to BCD conversion and digit shifting.
module dfa_bcd_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dfa_pkg::t_bcd_op           i_op,
    input  logic [dfa_pkg::MANT_W-1:0] i_mantissa,
    output dfa_pkg::t_bcd_stat         o_stat
);
    import dfa_pkg::*;

    logic [MANT_W-1:0] r_bin;
    logic [BCD_W-1:0]  r_bcd;
    logic [BCD_W-1:0]  adj;
    logic [MANT_W-1:0] sat;

    // Saturate the mantissa to the largest value the digit register holds.
    assign sat = (i_mantissa > MANT_CEIL) ? MANT_CEIL : i_mantissa;

    // Add three to every digit of five or more before the doubling shift.
    always_comb begin
        for (int d = 0; d < MANT_DIGITS; d++) begin
            adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ? r_bcd[4*d +: 4] + 4'd3
                                                      : r_bcd[4*d +: 4];
        end
    end

    // One operation per cycle, chosen by the sequencer.
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            BOP_LOAD: begin
                r_bin <= sat;
                r_bcd <= '0;
            end
            BOP_DABBLE: begin
                r_bcd <= {adj[BCD_W-2:0], r_bin[MANT_W-1]};
                r_bin <= {r_bin[MANT_W-2:0], 1'b0};
            end
            BOP_SHR: begin
                r_bcd <= {4'h0, r_bcd[BCD_W-1:4]};
            end
            BOP_SHL: begin
                r_bcd <= {r_bcd[BCD_W-5:0], 4'h0};
            end
            default: begin
            end
        endcase
    end

    // Status for the sequencer.
    assign o_stat.low_zero  = (r_bcd[3:0] == 4'h0);
    assign o_stat.top_zero  = (r_bcd[BCD_W-1 -: 4] == 4'h0);
    assign o_stat.top_digit = r_bcd[BCD_W-1 -: 4];

`ifndef ASSERT_OFF
    // Stripping may only drop a zero digit.
    a_strip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op == BOP_SHR |-> r_bcd[3:0] == 4'h0)
        else $error("BCD unit: a non-zero digit was stripped.");
`endif

endmodule

// File: sv/dfa_char_sel.sv
// Character selector: picks the character at one text position.
module dfa_char_sel (
    input  dfa_pkg::t_fmt             i_fmt,
    input  logic [dfa_pkg::POS_W-1:0] i_pos,
    input  logic [3:0]                i_digit,
    output logic [7:0]                o_char,
    output logic                      o_take
);
    import dfa_pkg::*;

    logic [POS_W-1:0] q;
    logic [7:0]       dig_char;

    // Position after the sign, and the ASCII form of the leading digit.
    assign q        = i_pos - POS_W'(i_fmt.neg);
    assign dig_char = {4'h3, i_digit};

    // Choose the character by layout; o_take consumes the leading digit.
    always_comb begin
        o_char = CH_ZERO;
        o_take = 1'b0;
        if (i_fmt.neg && i_pos == '0) begin
            o_char = CH_MINUS;
        end else begin
            unique case (i_fmt.mode)
                FM_ZERO: begin
                    o_char = CH_ZERO;
                end
                FM_INT: begin
                    if (q < i_fmt.split) begin
                        o_char = dig_char;
                        o_take = 1'b1;
                    end
                end
                FM_POINT: begin
                    if (q == i_fmt.split) begin
                        o_char = CH_POINT;
                    end else begin
                        o_char = dig_char;
                        o_take = 1'b1;
                    end
                end
                FM_FRAC: begin
                    priority if (q == POS_W'(1)) begin
                        o_char = CH_POINT;
                    end else if (q == '0 || q < i_fmt.split) begin
                        o_char = CH_ZERO;
                    end else begin
                        o_char = dig_char;
                        o_take = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: sv/dfa_ctrl.sv
// Sequencer: drives the BCD unit, lays out the text and packs chunks.
module dfa_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_sign_positive,
    input  logic signed [dfa_pkg::EXP_W-1:0] i_exponent,
    input  logic                             i_mant_zero,
    input  dfa_pkg::t_bcd_stat               i_stat,
    output dfa_pkg::t_bcd_op                 o_op,
    input  logic                             i_out_free,
    output logic                             o_push,
    output dfa_pkg::t_chunk                  o_chunk
);
    import dfa_pkg::*;

    t_state                   r_state, n_state;
    logic [STEP_W-1:0]        r_cnt;
    logic signed [EXP_W-1:0]  r_exp;
    logic                     r_neg;
    logic                     r_zero;
    logic [ND_W-1:0]          r_z;
    t_fmt                     r_fmt, n_fmt;
    logic [POS_W-1:0]         r_p;
    logic [CIDX_W-1:0]        r_ccnt;
    logic [CHARS_W-1:0]       r_chunk, n_chunk;

    logic                     accept;
    logic                     advance;
    logic                     complete;
    logic                     is_last;
    logic                     conv_done;
    logic [7:0]               ch;
    logic                     take;
    logic signed [EXP_W-1:0]  exp_clamp;
    logic [ND_W-1:0]          nd;
    logic signed [WIDE_W-1:0] e_w, nd_w, pos_w, off_w, len_w, split_w;

    assign accept    = i_valid && !o_stall;
    assign conv_done = (r_cnt == STEP_W'(MANT_W - 1));
    assign is_last   = (r_p == r_fmt.len - POS_W'(1));
    assign complete  = (r_ccnt == CIDX_W'(CHUNK_CHARS - 1)) || is_last;

    // Clamp the incoming exponent to its legal range.
    always_comb begin
        priority if (i_exponent < EXP_W'(EXP_LOW)) begin
            exp_clamp = EXP_W'(EXP_LOW);
        end else if (i_exponent > EXP_W'(EXP_HIGH)) begin
            exp_clamp = EXP_W'(EXP_HIGH);
        end else begin
            exp_clamp = i_exponent;
        end
    end

    // Text layout from the stripped exponent and the digit count.
    assign nd    = ND_W'(MANT_DIGITS) - r_z;
    assign e_w   = WIDE_W'(r_exp);
    assign nd_w  = WIDE_W'(nd);
    assign pos_w = nd_w + e_w;
    assign off_w = WIDE_W'(r_neg);

    always_comb begin
        n_fmt.neg = r_neg && !r_zero;
        priority if (r_zero) begin
            n_fmt.mode = FM_ZERO;
            split_w    = '0;
            len_w      = WIDE_W'(1);
        end else if (e_w >= 0) begin
            n_fmt.mode = FM_INT;
            split_w    = nd_w;
            len_w      = off_w + nd_w + e_w;
        end else if (pos_w > 0) begin
            n_fmt.mode = FM_POINT;
            split_w    = pos_w;
            len_w      = off_w + nd_w + WIDE_W'(1);
        end else begin
            n_fmt.mode = FM_FRAC;
            split_w    = WIDE_W'(2) - pos_w;
            len_w      = off_w + split_w + nd_w;
        end
        n_fmt.split = split_w[POS_W-1:0];
        n_fmt.len   = (len_w > WIDE_W'(TEXT_MAX)) ? POS_W'(TEXT_MAX) : len_w[POS_W-1:0];
    end

    dfa_char_sel u_char_sel (
        .i_fmt   (r_fmt),
        .i_pos   (r_p),
        .i_digit (i_stat.top_digit),
        .o_char  (ch),
        .o_take  (take)
    );

    // Place the new character into the chunk being built.
    always_comb begin
        n_chunk = r_chunk;
        n_chunk[{r_ccnt, 3'b000} +: 8] = ch;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = i_mant_zero ? ST_SETUP : ST_CONV;
                end
            end
            ST_CONV: begin
                if (conv_done) begin
                    n_state = ST_STRIP;
                end
            end
            ST_STRIP: begin
                if (!i_stat.low_zero) begin
                    n_state = ST_NORM;
                end
            end
            ST_NORM: begin
                if (!i_stat.top_zero) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (advance && is_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State outputs and unit operations.
    always_comb begin
        o_stall = 1'b1;
        o_op    = BOP_HOLD;
        advance = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (accept) begin
                    o_op = BOP_LOAD;
                end
            end
            ST_CONV: begin
                o_op = BOP_DABBLE;
            end
            ST_STRIP: begin
                if (i_stat.low_zero) begin
                    o_op = BOP_SHR;
                end
            end
            ST_NORM: begin
                if (i_stat.top_zero) begin
                    o_op = BOP_SHL;
                end
            end
            ST_SETUP: begin
            end
            ST_EMIT: begin
                advance = i_out_free || !complete;
                if (advance && take) begin
                    o_op = BOP_SHL;
                end
            end
            default: begin
            end
        endcase
    end

    // A finished chunk goes to the output register.
    assign o_push        = advance && complete;
    assign o_chunk.chars = n_chunk;
    assign o_chunk.count = CNT_W'(r_ccnt) + CNT_W'(1);
    assign o_chunk.last  = is_last;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working registers of the sequencer.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_neg  <= !i_sign_positive;
            r_zero <= i_mant_zero;
            r_exp  <= exp_clamp;
            r_cnt  <= '0;
            r_z    <= '0;
        end
        if (r_state == ST_CONV) begin
            r_cnt <= r_cnt + STEP_W'(1);
        end
        if (r_state == ST_STRIP && i_stat.low_zero) begin
            r_exp <= r_exp + EXP_W'(1);
        end
        if (r_state == ST_NORM && i_stat.top_zero) begin
            r_z <= r_z + ND_W'(1);
        end
        if (r_state == ST_SETUP) begin
            r_fmt   <= n_fmt;
            r_p     <= '0;
            r_ccnt  <= '0;
            r_chunk <= '0;
        end
        if (advance) begin
            r_p <= r_p + POS_W'(1);
            if (complete) begin
                r_ccnt  <= '0;
                r_chunk <= '0;
            end else begin
                r_ccnt  <= r_ccnt + CIDX_W'(1);
                r_chunk <= n_chunk;
            end
        end
    end

`ifndef ASSERT_OFF
    // The conversion runs its full count of steps.
    a_conv_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV && !conv_done) |=> r_state == ST_CONV)
        else $error("Sequencer: conversion left early.");

    // A chunk is only pushed when the output register can take it.
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_out_free)
        else $error("Sequencer: chunk pushed into a full output register.");

    // Emission never runs past the end of the text.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT |-> r_p < r_fmt.len)
        else $error("Sequencer: text position beyond text length.");
`endif

endmodule

// File: sv/decimal_float_to_ascii_formatter_core.sv
// Formats a decimal floating-point amount as ASCII text in chunks of eight.
// Each item passes through the 54-step BCD conversion, the stripping of trailing
// zeros and the skipping of leading zero digits, then emits one text character per
// cycle, held while a finished chunk waits for the output register; a zero mantissa
// goes straight to the text set-up. The text holds at most 104 characters; the next
// item is taken once the last chunk is in the output register. Reset is synchronous
// and active low; it returns the sequencer to idle and empties the output register.
module decimal_float_to_ascii_formatter_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_sign_positive,
    input  logic signed [dfa_pkg::EXP_W-1:0]  i_exponent,
    input  logic [dfa_pkg::MANT_W-1:0]        i_mantissa,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [dfa_pkg::CHARS_W-1:0]       o_chars,
    output logic [dfa_pkg::CNT_W-1:0]         o_char_count,
    output logic                              o_last
);
    import dfa_pkg::*;

    t_bcd_op   op;
    t_bcd_stat stat;
    t_chunk    chunk;
    logic      push;
    logic      out_free;
    logic      mant_zero;
    logic      r_ovalid;
    t_chunk    r_out;

    assign mant_zero = (i_mantissa == '0);
    assign out_free  = !r_ovalid || !i_stall;

    dfa_bcd_unit u_bcd (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (op),
        .i_mantissa (i_mantissa),
        .o_stat     (stat)
    );

    dfa_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_sign_positive (i_sign_positive),
        .i_exponent      (i_exponent),
        .i_mant_zero     (mant_zero),
        .i_stat          (stat),
        .o_op            (op),
        .i_out_free      (out_free),
        .o_push          (push),
        .o_chunk         (chunk)
    );

    // Output register: holds a chunk until its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (push) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out <= chunk;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_chars      = r_out.chars;
    assign o_char_count = r_out.count;
    assign o_last       = r_out.last;

endmodule

// File: dv/dfa_text_checker.sv
// Channel monitor and text predictor that checks each output chunk of the formatter.
`timescale 1ns / 100ps

module dfa_text_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic                             o_stall,
    input  logic                             i_sign_positive,
    input  logic signed [dfa_pkg::EXP_W-1:0] i_exponent,
    input  logic [dfa_pkg::MANT_W-1:0]       i_mantissa,
    input  logic                             o_valid,
    input  logic                             i_stall,
    input  logic [dfa_pkg::CHARS_W-1:0]      o_chars,
    input  logic [dfa_pkg::CNT_W-1:0]        o_char_count,
    input  logic                             o_last,
    output int                               mismatches,
    output int                               pending,
    output int                               amounts,
    output int                               chunks,
    output int                               negatives,
    output int                               fractions
);
    import dfa_pkg::*;

    // Chunks still owed by the block, oldest first.
    t_chunk text_chunks_due[$];

    // One line per mismatch, and a count for the verdict.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] MISMATCH in chunk %0d, %s: got %h, expected %h",
                 $realtime, chunks, what, got, want);
        mismatches++;
    endtask

    // Builds the text of one amount and queues the chunks it should produce.
    function automatic void format_amount(input logic sgn, input logic signed [EXP_W-1:0] exp_in,
                                          input logic [MANT_W-1:0] mant_in);
        int                e;
        int                nd;
        int                point_at;
        int                len;
        int                n_out;
        int                cnt;
        longint unsigned   m;
        logic [7:0]        digits[$];
        logic [7:0]        text[$];
        t_mode             mode;
        t_chunk            c;

        // Clamp the exponent and saturate the mantissa first.
        e = exp_in;
        if (e < EXP_LOW) e = EXP_LOW;
        if (e > EXP_HIGH) e = EXP_HIGH;
        m = mant_in;
        if (m > MANT_CEIL) m = MANT_CEIL;

        if (m == 0) begin
            mode = FM_ZERO;
            text.push_back(CH_ZERO);
        end else begin
            // Trailing zeros move into the exponent.
            while (m % 10 == 0) begin
                m = m / 10;
                e++;
            end
            // Digits end up most significant first.
            while (m > 0) begin
                digits.push_front(CH_ZERO + 8'(m % 10));
                m = m / 10;
            end
            nd = digits.size();
            if (!sgn) text.push_back(CH_MINUS);
            point_at = nd + e;
            if (e >= 0) begin
                mode = FM_INT;
                foreach (digits[i]) text.push_back(digits[i]);
                for (int i = 0; i < e; i++) text.push_back(CH_ZERO);
            end else if (point_at > 0) begin
                mode = FM_POINT;
                foreach (digits[i]) begin
                    if (i == point_at) text.push_back(CH_POINT);
                    text.push_back(digits[i]);
                end
            end else begin
                mode = FM_FRAC;
                text.push_back(CH_ZERO);
                text.push_back(CH_POINT);
                for (int i = 0; i < -point_at; i++) text.push_back(CH_ZERO);
                foreach (digits[i]) text.push_back(digits[i]);
            end
            if (!sgn) negatives++;
        end
        if (mode == FM_FRAC) fractions++;

        // Cut the text into chunks, first character in the low byte.
        len = (text.size() > TEXT_MAX) ? TEXT_MAX : text.size();
        n_out = (len + CHUNK_CHARS - 1) / CHUNK_CHARS;
        for (int k = 0; k < n_out; k++) begin
            cnt = len - k * CHUNK_CHARS;
            if (cnt > CHUNK_CHARS) cnt = CHUNK_CHARS;
            c.chars = '0;
            for (int i = 0; i < cnt; i++) c.chars[8*i +: 8] = text[k * CHUNK_CHARS + i];
            c.count = CNT_W'(cnt);
            c.last  = (k == n_out - 1);
            text_chunks_due.push_back(c);
        end
    endfunction

    // Outputs are checked before a new amount is queued, as a chunk accepted at
    // the same edge can only belong to an earlier amount.
    always @(posedge i_clk) begin
        t_chunk want;
        if (!i_rst_n) begin
            text_chunks_due.delete();
            mismatches = 0;
            amounts    = 0;
            chunks     = 0;
            negatives  = 0;
            fractions  = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (text_chunks_due.size() == 0) begin
                    report_mismatch("unexpected chunk", o_chars, '0);
                end else begin
                    want = text_chunks_due.pop_front();
                    if (o_chars !== want.chars) report_mismatch("chars", o_chars, want.chars);
                    if (o_char_count !== want.count)
                        report_mismatch("char_count", 64'(o_char_count), 64'(want.count));
                    if (o_last !== want.last)
                        report_mismatch("last", 64'(o_last), 64'(want.last));
                end
                chunks++;
            end
            if (i_valid && !o_stall) begin
                format_amount(i_sign_positive, i_exponent, i_mantissa);
                amounts++;
            end
        end
        pending = text_chunks_due.size();
    end

endmodule

// File: dv/decimal_float_to_ascii_formatter_core_tb.sv
// Top of the formatter testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module decimal_float_to_ascii_formatter_core_tb;
    import dfa_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 250;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic                    i_sign_positive;
    logic signed [EXP_W-1:0] i_exponent;
    logic [MANT_W-1:0]       i_mantissa;
    logic                    o_valid;
    logic                    i_stall;
    logic [CHARS_W-1:0]      o_chars;
    logic [CNT_W-1:0]        o_char_count;
    logic                    o_last;

    int mismatches;
    int pending;
    int amounts;
    int chunks;
    int negatives;
    int fractions;

    // Set by the stimulus, read by the receiver.
    bit quiet;
    bit hold_request;
    bit hold_served;

    decimal_float_to_ascii_formatter_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_sign_positive (i_sign_positive),
        .i_exponent      (i_exponent),
        .i_mantissa      (i_mantissa),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_chars         (o_chars),
        .o_char_count    (o_char_count),
        .o_last          (o_last)
    );

    dfa_text_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_sign_positive (i_sign_positive),
        .i_exponent      (i_exponent),
        .i_mantissa      (i_mantissa),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_chars         (o_chars),
        .o_char_count    (o_char_count),
        .o_last          (o_last),
        .mismatches      (mismatches),
        .pending         (pending),
        .amounts         (amounts),
        .chunks          (chunks),
        .negatives       (negatives),
        .fractions       (fractions)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit: a hung block ends the run here.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Run stopped after %0d cycles with %0d chunks outstanding.", cycles, pending);
        $display("decimal_float_to_ascii_formatter_core test failed");
        $finish;
    end

    // Receiver: random stalls, none while quiet, and one long hold-off.
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_served) begin
                hold_served = 1'b1;
                i_stall <= 1'b1;
                for (int n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (!quiet && $urandom_range(99) < 9) begin
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    function automatic longint unsigned pow10(input int n);
        longint unsigned p;
        p = 1;
        for (int i = 0; i < n; i++) p = p * 10;
        return p;
    endfunction

    // Offers one amount, with an occasional gap first, and returns once the
    // transfer has taken place.
    task automatic send_amount(input logic sgn, input logic signed [EXP_W-1:0] e,
                               input logic [MANT_W-1:0] m);
        if (!quiet && $urandom_range(99) < 9) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_sign_positive <= sgn;
        i_exponent      <= e;
        i_mantissa      <= m;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Mostly in-range digit strings, some with trailing zeros, some zero and
    // some raw 54-bit values, many of which saturate.
    function automatic logic [MANT_W-1:0] random_mantissa();
        longint unsigned raw;
        int              pick;
        int              digits;
        int              zeros;
        raw    = {$urandom, $urandom};
        pick   = $urandom_range(99);
        digits = $urandom_range(16, 1);
        zeros  = (pick < 45) ? $urandom_range(16 - digits, 0) : 0;
        if (pick < 5) return '0;
        if (pick < 15) return raw[MANT_W-1:0];
        return MANT_W'((raw % pow10(digits)) * pow10(zeros));
    endfunction

    function automatic logic signed [EXP_W-1:0] random_exponent();
        if ($urandom_range(99) < 85) return EXP_W'($urandom_range(EXP_HIGH - EXP_LOW) + EXP_LOW);
        return EXP_W'($urandom);
    endfunction

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++)
            send_amount(1'($urandom_range(1)), random_exponent(), random_mantissa());
    endtask

    // Stimulus and verdict.
    initial begin
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_sign_positive <= 1'b0;
        i_exponent      <= '0;
        i_mantissa      <= '0;
        quiet        = 1'b0;
        hold_request = 1'b0;
        hold_served  = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero mantissa whatever the sign and exponent.
        send_amount(1'b1, EXP_W'(0), '0);
        send_amount(1'b0, 8'h80, '0);
        send_amount(1'b1, 8'h7F, '0);
        // Single digits at the exponent extremes, clamped or not.
        send_amount(1'b1, EXP_W'(0), 54'd1);
        send_amount(1'b0, EXP_W'(EXP_HIGH), 54'd1);
        send_amount(1'b1, 8'h7F, 54'd1);
        send_amount(1'b1, EXP_W'(EXP_LOW), 54'd1);
        send_amount(1'b0, 8'h80, 54'd1);
        send_amount(1'b1, 8'h9F, 54'd7);
        // Full sixteen digits with integer, point and fraction layouts.
        send_amount(1'b1, EXP_W'(0), MANT_CEIL);
        send_amount(1'b0, EXP_W'(-8), MANT_CEIL);
        send_amount(1'b1, EXP_W'(-16), MANT_CEIL);
        // Stripping pushes the exponent past its upper limit.
        send_amount(1'b0, EXP_W'(EXP_HIGH), 54'd1000000000000000);
        // Oversized mantissas saturate; the last value, 2^53, lies below the ceiling.
        send_amount(1'b1, EXP_W'(-3), {MANT_W{1'b1}});
        send_amount(1'b0, EXP_W'(0), 54'd10000000000000000);
        send_amount(1'b1, EXP_W'(0), 54'h20000000000000);
        // Point placement and stripping.
        send_amount(1'b1, EXP_W'(-4), 54'd123456789);
        send_amount(1'b1, EXP_W'(-1), 54'd120);
        send_amount(1'b0, EXP_W'(-5), 54'd1200);
        send_amount(1'b1, EXP_W'(-1), 54'd5);
        // Chunk boundaries around eight characters.
        send_amount(1'b1, EXP_W'(0), 54'd12345678);
        send_amount(1'b0, EXP_W'(0), 54'd1234567);
        send_amount(1'b1, EXP_W'(0), 54'd123456789);

        // Random amounts: normal idling, then a quiet stretch, then a long
        // hold-off by the receiver while amounts keep coming.
        send_random(60);
        quiet = 1'b1;
        send_random(40);
        quiet = 1'b0;
        hold_request = 1'b1;
        send_random(20);
        send_random(30);
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d amounts giving %0d text chunks.", amounts, chunks);
        $display("Of these %0d were negative and %0d printed below one.", negatives, fractions);
        if (mismatches == 0 && pending == 0) begin
            $display("decimal_float_to_ascii_formatter_core test passed");
        end else begin
            $display("decimal_float_to_ascii_formatter_core test failed");
        end
        $finish;
    end

endmodule
